FILE: hdl/gfc_pkg.sv
`timescale 1ns / 1ps
// Shared operation codes, register indexes and field widths of the frame compositor.
package gfc_pkg;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpHeader = 2'd1,
    OpPixel  = 2'd2,
    OpRead   = 2'd3
  } gfc_op_e;

  typedef enum logic [1:0] {
    CfgCanvasWidth  = 2'd0,
    CfgCanvasHeight = 2'd1,
    CfgBackground   = 2'd2,
    CfgUnused       = 2'd3
  } gfc_cfg_e;

  localparam logic [2:0] DisposeRestoreBg = 3'd2;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CanvasSizeW = 9;
  localparam int unsigned ReadPosW = 8;

endpackage

FILE: hdl/gfc_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for compositor items and read results.
interface gfc_item_if;
  import gfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [CoordW-1:0]   frame_left;
  logic [CoordW-1:0]   frame_top;
  logic [CoordW-1:0]   frame_width;
  logic [CoordW-1:0]   frame_height;
  logic [2:0]          disposal;
  logic [ColorW-1:0]   pixel_color;
  logic [ReadPosW-1:0] read_x;
  logic [ReadPosW-1:0] read_y;

  modport source (
    output valid, operation, frame_left, frame_top, frame_width, frame_height,
           disposal, pixel_color, read_x, read_y,
    input  ready
  );
  modport sink (
    input  valid, operation, frame_left, frame_top, frame_width, frame_height,
           disposal, pixel_color, read_x, read_y,
    output ready
  );
endinterface

interface gfc_result_if;
  import gfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ColorW-1:0] read_color;

  modport source (output valid, read_color, input ready);
  modport sink (input valid, read_color, output ready);
endinterface

FILE: hdl/gfc_rect_walk.sv
`timescale 1ns / 1ps
// Raster walker that steps through a non-empty rectangle one pixel per cycle.
module gfc_rect_walk #(
  parameter int unsigned XW = 9,
  parameter int unsigned YW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x0_i,
  input  logic [XW-1:0] x1_i,
  input  logic [YW-1:0] y0_i,
  input  logic [YW-1:0] y1_i,
  output logic          busy_o,
  output logic          last_o,
  output logic [XW-1:0] x_o,
  output logic [YW-1:0] y_o
);

  logic          busy_q, busy_d;
  logic [XW-1:0] x_q, x_d, x0_q, x0_d, x1_q, x1_d;
  logic [YW-1:0] y_q, y_d, y1_q, y1_d;
  logic [XW-1:0] x_inc;
  logic [YW-1:0] y_inc;
  logic          row_end;

  assign x_inc   = x_q + XW'(1);
  assign y_inc   = y_q + YW'(1);
  assign row_end = (x_inc == x1_q);

  always_comb begin
    busy_d = busy_q;
    x_d    = x_q;
    y_d    = y_q;
    x0_d   = x0_q;
    x1_d   = x1_q;
    y1_d   = y1_q;
    if (start_i) begin
      busy_d = 1'b1;
      x_d    = x0_i;
      y_d    = y0_i;
      x0_d   = x0_i;
      x1_d   = x1_i;
      y1_d   = y1_i;
    end else if (busy_q) begin
      if (row_end) begin
        x_d = x0_q;
        y_d = y_inc;
        if (y_inc == y1_q) begin
          busy_d = 1'b0;
        end
      end else begin
        x_d = x_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    x0_q <= x0_d;
    x1_q <= x1_d;
    y1_q <= y1_d;
  end

  assign busy_o = busy_q;
  assign last_o = busy_q && row_end && (y_inc == y1_q);
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

FILE: hdl/gif_frame_compositor_unit.sv
`timescale 1ns / 1ps
// Animation frame compositor: clears, disposes and overwrites a stored pixel canvas
// and answers pixel reads. All canvas writes go through the single write port of
// the canvas memory, one pixel per cycle. Pixel items stream back to back. A read
// item passes through the registered memory read and then the output register, and
// may wait further for the sink. A clear fills the active canvas W by H with the
// background, and a header whose previous frame had disposal 2 fills the area of
// that frame clipped to the canvas; other headers start no fill. No input is taken
// during those fills.
// No memory initialization is done: the canvas must be cleared before it is read.
module gif_frame_compositor_unit
  import gfc_pkg::*;
#(
  parameter int unsigned MAX_CANVAS_WIDTH  = 256,
  parameter int unsigned MAX_CANVAS_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  gfc_item_if.sink    item_i,
  gfc_result_if.source result_o
);

  localparam int unsigned Depth = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CXW   = $clog2(MAX_CANVAS_WIDTH + 1);
  localparam int unsigned CYW   = $clog2(MAX_CANVAS_HEIGHT + 1);
  localparam int unsigned PW    = CoordW + 1;
  localparam logic [PW-1:0] MaxW = PW'(MAX_CANVAS_WIDTH);
  localparam logic [PW-1:0] MaxH = PW'(MAX_CANVAS_HEIGHT);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StFill = 3'b010,
    StRead = 3'b100
  } gfc_state_e;

  gfc_state_e state_q, state_d;

  // Configuration registers.
  logic [CanvasSizeW-1:0] cw_q, ch_q;
  logic [ColorW-1:0]      bg_q;

  // Frame state.
  logic [CoordW-1:0] prev_left_q, prev_top_q, prev_width_q, prev_height_q;
  logic [2:0]        prev_disp_q;
  logic [CoordW-1:0] pix_col_q, pix_col_d, pix_row_q, pix_row_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [ColorW-1:0] out_color_q, out_color_d;

  // Canvas memory.
  logic [ColorW-1:0] canvas_mem [Depth];
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ColorW-1:0] mem_wdata, mem_rdata_q;
  logic              rd_zero_q;

  gfc_op_e           op;
  logic              in_fire, out_take, out_free;
  logic [PW-1:0]     aw, ah;
  logic [PW-1:0]     disp_x1_raw, disp_y1_raw, disp_x1, disp_y1;
  logic              clr_ne, disp_ne;
  logic [PW-1:0]     pix_cx, pix_cy, col_inc;
  logic              pix_live, pix_ok;

  logic              walk_start, walk_busy, walk_last;
  logic [CXW-1:0]    walk_x0, walk_x1, walk_x;
  logic [CYW-1:0]    walk_y0, walk_y1, walk_y;

  assign op       = gfc_op_e'(item_i.operation);
  assign in_fire  = item_i.valid && item_i.ready;
  assign out_take = result_o.valid && result_o.ready;
  assign out_free = !out_valid_q || result_o.ready;

  assign item_i.ready      = (state_q == StIdle);
  assign result_o.valid    = out_valid_q;
  assign result_o.read_color = out_color_q;

  // Active canvas size, saturated at the memory's dimensions.
  assign aw = (PW'(cw_q) > MaxW) ? MaxW : PW'(cw_q);
  assign ah = (PW'(ch_q) > MaxH) ? MaxH : PW'(ch_q);

  assign clr_ne = (aw != '0) && (ah != '0);

  assign disp_x1_raw = PW'(prev_left_q) + PW'(prev_width_q);
  assign disp_y1_raw = PW'(prev_top_q) + PW'(prev_height_q);
  assign disp_x1     = (disp_x1_raw > aw) ? aw : disp_x1_raw;
  assign disp_y1     = (disp_y1_raw > ah) ? ah : disp_y1_raw;
  assign disp_ne     = (prev_disp_q == DisposeRestoreBg) &&
                       (PW'(prev_left_q) < disp_x1) && (PW'(prev_top_q) < disp_y1);

  always_comb begin
    walk_start = 1'b0;
    walk_x0    = '0;
    walk_y0    = '0;
    walk_x1    = CXW'(aw);
    walk_y1    = CYW'(ah);
    if (in_fire && op == OpClear) begin
      walk_start = clr_ne;
    end else if (in_fire && op == OpHeader) begin
      walk_start = disp_ne;
      walk_x0    = CXW'(prev_left_q);
      walk_y0    = CYW'(prev_top_q);
      walk_x1    = CXW'(disp_x1);
      walk_y1    = CYW'(disp_y1);
    end
  end

  gfc_rect_walk #(
    .XW(CXW),
    .YW(CYW)
  ) u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(walk_start),
    .x0_i   (walk_x0),
    .x1_i   (walk_x1),
    .y0_i   (walk_y0),
    .y1_i   (walk_y1),
    .busy_o (walk_busy),
    .last_o (walk_last),
    .x_o    (walk_x),
    .y_o    (walk_y)
  );

  // Pixel placement inside the current frame.
  assign pix_cx   = PW'(prev_left_q) + PW'(pix_col_q);
  assign pix_cy   = PW'(prev_top_q) + PW'(pix_row_q);
  assign pix_live = (pix_row_q < prev_height_q);
  assign pix_ok   = pix_live && (pix_cx < aw) && (pix_cy < ah) &&
                    (item_i.pixel_color[ColorW-1:ColorW-8] != 8'd0);
  assign col_inc  = PW'(pix_col_q) + PW'(1);

  always_comb begin
    pix_col_d = pix_col_q;
    pix_row_d = pix_row_q;
    if (in_fire) begin
      unique case (op)
        OpClear, OpHeader: begin
          pix_col_d = '0;
          pix_row_d = '0;
        end
        OpPixel: begin
          if (pix_live) begin
            if (col_inc >= PW'(prev_width_q)) begin
              pix_col_d = '0;
              pix_row_d = pix_row_q + CoordW'(1);
            end else begin
              pix_col_d = col_inc[CoordW-1:0];
            end
          end
        end
        OpRead: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Single write port: fill walker while it runs, frame pixels otherwise.
  always_comb begin
    if (walk_busy) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(walk_y) * AW'(MAX_CANVAS_WIDTH) + AW'(walk_x);
      mem_wdata = bg_q;
    end else begin
      mem_we    = in_fire && (op == OpPixel) && pix_ok;
      mem_waddr = AW'(pix_cy) * AW'(MAX_CANVAS_WIDTH) + AW'(pix_cx);
      mem_wdata = item_i.pixel_color;
    end
  end

  assign mem_re    = in_fire && (op == OpRead);
  assign mem_raddr = AW'(item_i.read_y) * AW'(MAX_CANVAS_WIDTH) + AW'(item_i.read_x);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= canvas_mem[mem_raddr];
      rd_zero_q   <= !((PW'(item_i.read_x) < aw) && (PW'(item_i.read_y) < ah));
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_color_d = out_color_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (walk_start) begin
          state_d = StFill;
        end else if (mem_re) begin
          state_d = StRead;
        end
      end
      StFill: begin
        if (walk_last) begin
          state_d = StIdle;
        end
      end
      StRead: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_color_d = rd_zero_q ? '0 : mem_rdata_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      cw_q          <= CanvasSizeW'(256);
      ch_q          <= CanvasSizeW'(256);
      bg_q          <= '0;
      prev_left_q   <= '0;
      prev_top_q    <= '0;
      prev_width_q  <= '0;
      prev_height_q <= '0;
      prev_disp_q   <= '0;
      pix_col_q     <= '0;
      pix_row_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pix_col_q   <= pix_col_d;
      pix_row_q   <= pix_row_d;
      if (cfg_we_i) begin
        unique case (gfc_cfg_e'(cfg_idx_i))
          CfgCanvasWidth:  cw_q <= cfg_wdata_i[CanvasSizeW-1:0];
          CfgCanvasHeight: ch_q <= cfg_wdata_i[CanvasSizeW-1:0];
          CfgBackground:   bg_q <= cfg_wdata_i;
          CfgUnused: begin
          end
          default: begin
          end
        endcase
      end
      if (in_fire && op == OpClear) begin
        prev_disp_q <= '0;
      end else if (in_fire && op == OpHeader) begin
        prev_left_q   <= item_i.frame_left;
        prev_top_q    <= item_i.frame_top;
        prev_width_q  <= item_i.frame_width;
        prev_height_q <= item_i.frame_height;
        prev_disp_q   <= item_i.disposal;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_color_q <= out_color_d;
  end

`ifndef SYNTHESIS
  // The walker only runs while the control sits in the fill state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_busy |-> (state_q == StFill))
    else $error("fill walker active outside fill state");

  // Nothing may write the canvas while a read is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != StRead))
    else $error("canvas write during read");

  // An accepted read must move the control to the read state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op == OpRead) |=> (state_q == StRead))
    else $error("read transaction not followed by read state");

  // The column counter wraps before it reaches the frame width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_col_q == '0) || (pix_col_q < prev_width_q))
    else $error("pixel column beyond frame width");
`endif

endmodule

FILE: dv/gfc_canvas_checker.sv
`timescale 1ns / 1ps
// Checker that mirrors the compositor canvas and compares every read result in order.
module gfc_canvas_checker
  import gfc_pkg::*;
#(
  parameter int unsigned MAX_CANVAS_WIDTH  = 256,
  parameter int unsigned MAX_CANVAS_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  gfc_item_if         item_i,
  gfc_result_if       result_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned CanvasArea = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;

  logic [ColorW-1:0]      canvas_mem [CanvasArea];
  logic [CanvasSizeW-1:0] canvas_w;
  logic [CanvasSizeW-1:0] canvas_h;
  logic [ColorW-1:0]      bg_color;
  int unsigned            frame_left;
  int unsigned            frame_top;
  int unsigned            frame_w;
  int unsigned            frame_h;
  logic [2:0]             frame_disposal;
  int unsigned            walk_col;
  int unsigned            walk_row;
  logic [ColorW-1:0]      expected_colors [$];
  int                     mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned visible_width();
    return (canvas_w > MAX_CANVAS_WIDTH) ? MAX_CANVAS_WIDTH : 32'(canvas_w);
  endfunction

  function automatic int unsigned visible_height();
    return (canvas_h > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : 32'(canvas_h);
  endfunction

  // Rectangle fill clipped to the visible canvas; an origin past the edge fills nothing.
  function automatic void fill_area(input int unsigned left, input int unsigned top,
                                    input int unsigned w, input int unsigned h,
                                    input logic [ColorW-1:0] color);
    int unsigned x_end;
    int unsigned y_end;
    x_end = left + w;
    y_end = top + h;
    if (x_end > visible_width()) x_end = visible_width();
    if (y_end > visible_height()) y_end = visible_height();
    for (int unsigned y = top; y < y_end; y++) begin
      for (int unsigned x = left; x < x_end; x++) begin
        canvas_mem[y * MAX_CANVAS_WIDTH + x] = color;
      end
    end
  endfunction

  function automatic void apply_item();
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [ColorW-1:0] color;
    case (gfc_op_e'(item_i.operation))
      OpClear: begin
        fill_area(0, 0, visible_width(), visible_height(), bg_color);
        frame_disposal = '0;
        walk_col = 0;
        walk_row = 0;
      end
      OpHeader: begin
        if (frame_disposal == DisposeRestoreBg) begin
          fill_area(frame_left, frame_top, frame_w, frame_h, bg_color);
        end
        frame_left = 32'(item_i.frame_left);
        frame_top = 32'(item_i.frame_top);
        frame_w = 32'(item_i.frame_width);
        frame_h = 32'(item_i.frame_height);
        frame_disposal = item_i.disposal;
        walk_col = 0;
        walk_row = 0;
      end
      OpPixel: begin
        color = item_i.pixel_color;
        if (walk_row < frame_h) begin
          col_pos = frame_left + walk_col;
          row_pos = frame_top + walk_row;
          if (col_pos < visible_width() && row_pos < visible_height() &&
              color[31:24] != 8'd0) begin
            canvas_mem[row_pos * MAX_CANVAS_WIDTH + col_pos] = color;
          end
          walk_col++;
          if (walk_col >= frame_w) begin
            walk_col = 0;
            walk_row++;
          end
        end
      end
      OpRead: begin
        col_pos = 32'(item_i.read_x);
        row_pos = 32'(item_i.read_y);
        color = '0;
        if (col_pos < visible_width() && row_pos < visible_height()) begin
          color = canvas_mem[row_pos * MAX_CANVAS_WIDTH + col_pos];
        end
        expected_colors = {expected_colors, color};
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    logic [ColorW-1:0] want;
    if (expected_colors.size() == 0) begin
      mismatches++;
      $display("%0t: read_color expected none, actual %08h", $time, result_i.read_color);
    end else begin
      want = expected_colors.pop_front();
      if (result_i.read_color !== want) begin
        mismatches++;
        $display("%0t: read_color expected %08h, actual %08h", $time, want,
                 result_i.read_color);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w = 9'd256;
      canvas_h = 9'd256;
      bg_color = '0;
      frame_left = 0;
      frame_top = 0;
      frame_w = 0;
      frame_h = 0;
      frame_disposal = '0;
      walk_col = 0;
      walk_row = 0;
      expected_colors.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (gfc_cfg_e'(cfg_idx_i))
          CfgCanvasWidth:  canvas_w = cfg_wdata_i[CanvasSizeW-1:0];
          CfgCanvasHeight: canvas_h = cfg_wdata_i[CanvasSizeW-1:0];
          CfgBackground:   bg_color = cfg_wdata_i;
          default: ;
        endcase
      end
      // A result leaving this cycle always belongs to an older read, so compare first.
      if (result_i.valid && result_i.ready) check_result();
      if (item_i.valid && item_i.ready) apply_item();
      pending_o <= expected_colors.size();
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top: drives compositor items and configuration, paces results, gives the verdict.
module testbench;
  import gfc_pkg::*;

  localparam int unsigned MaxW = 256;
  localparam int unsigned MaxH = 256;
  // Longest quiet stretch is a full 256x256 clear plus a held-off result.
  localparam int unsigned StallLimit = 300000;
  localparam int unsigned HoldCycles = 300;
  localparam logic [2:0] DisposeNone = 3'd0;
  localparam logic [2:0] DisposePrevious = 3'd3;
  localparam logic [2:0] DisposeReservedTop = 3'd7;

  typedef struct {
    gfc_op_e     op;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  disposal;
    logic [31:0] color;
    logic [7:0]  rx;
    logic [7:0]  ry;
  } comp_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  int unsigned active_w = MaxW;
  int unsigned active_h = MaxH;
  bit          rush_items = 1'b0;
  bit          hold_results = 1'b0;
  int unsigned sender_calm = 0;
  int unsigned sink_calm = 0;
  int unsigned idle_cycles = 0;
  int          fail_count;
  int          pending;

  gfc_item_if   item_bus ();
  gfc_result_if result_bus ();

  gif_frame_compositor_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  gfc_canvas_checker u_canvas_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .item_i       (item_bus),
    .result_i     (result_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Fields that the operation does not use carry random values.
  function automatic comp_item_t junk_item();
    comp_item_t it;
    it.op = gfc_op_e'($urandom_range(0, 3));
    it.left = 16'($urandom);
    it.top = 16'($urandom);
    it.width = 16'($urandom);
    it.height = 16'($urandom);
    it.disposal = 3'($urandom);
    it.color = $urandom;
    it.rx = 8'($urandom);
    it.ry = 8'($urandom);
    return it;
  endfunction

  function automatic comp_item_t clear_item();
    comp_item_t it;
    it = junk_item();
    it.op = OpClear;
    return it;
  endfunction

  function automatic comp_item_t header_item(input int unsigned l, input int unsigned t,
                                             input int unsigned w, input int unsigned h,
                                             input logic [2:0] d);
    comp_item_t it;
    it = junk_item();
    it.op = OpHeader;
    it.left = 16'(l);
    it.top = 16'(t);
    it.width = 16'(w);
    it.height = 16'(h);
    it.disposal = d;
    return it;
  endfunction

  function automatic comp_item_t pixel_item(input logic [31:0] c);
    comp_item_t it;
    it = junk_item();
    it.op = OpPixel;
    it.color = c;
    return it;
  endfunction

  function automatic comp_item_t read_item(input int unsigned x, input int unsigned y);
    comp_item_t it;
    it = junk_item();
    it.op = OpRead;
    it.rx = 8'(x);
    it.ry = 8'(y);
    return it;
  endfunction

  // Each coordinate falls near the visible canvas half the time, anywhere in the address range otherwise.
  function automatic comp_item_t random_read();
    int unsigned x_lim;
    int unsigned y_lim;
    x_lim = (active_w + 1 > 255) ? 255 : active_w + 1;
    y_lim = (active_h + 1 > 255) ? 255 : active_h + 1;
    return read_item($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, x_lim),
                     $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, y_lim));
  endfunction

  function automatic logic [31:0] random_color();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 4) == 0) c[31:24] = 8'd0;
    return c;
  endfunction

  task automatic send(input comp_item_t it);
    int unsigned gap;
    if (sender_calm != 0) sender_calm--;
    else if ($urandom_range(0, 15) == 0) sender_calm = 20;
    gap = (rush_items || sender_calm != 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.operation <= it.op;
    item_bus.frame_left <= it.left;
    item_bus.frame_top <= it.top;
    item_bus.frame_width <= it.width;
    item_bus.frame_height <= it.height;
    item_bus.disposal <= it.disposal;
    item_bus.pixel_color <= it.color;
    item_bus.read_x <= it.rx;
    item_bus.read_y <= it.ry;
    do @(posedge clk_i); while (!item_bus.ready);
  endtask

  // Every phase ends with a read, so its result arriving means all fills are done.
  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input logic [31:0] bg);
    cfg_we <= 1'b1;
    cfg_idx <= CfgCanvasWidth;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_idx <= CfgCanvasHeight;
    cfg_wdata <= h;
    @(posedge clk_i);
    cfg_idx <= CfgBackground;
    cfg_wdata <= bg;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    active_w = (w > MaxW) ? MaxW : w;
    active_h = (h > MaxH) ? MaxH : h;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    int unsigned pixels;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Frame: header, then its pixel stream (sometimes short or long) with a few reads mixed in.
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
        send(header_item($urandom_range(0, active_w + 1), $urandom_range(0, active_h + 1),
                         w, h,
                         $urandom_range(0, 1) ? DisposeRestoreBg : 3'($urandom_range(0, 7))));
        pixels = w * h;
        case ($urandom_range(0, 7))
          0: pixels = $urandom_range(0, pixels);
          1: pixels += $urandom_range(1, 3);
          default: ;
        endcase
        sent += 1 + pixels;
        repeat (pixels) begin
          if ($urandom_range(0, 5) == 0) begin
            send(random_read());
            sent++;
          end
          send(pixel_item(random_color()));
        end
      end else if (pick < 77) begin
        send(random_read());
        sent++;
      end else if (pick < 82) begin
        // Full-size clears are too slow to repeat, so large canvases get a read instead.
        if (active_w * active_h <= 4096) send(clear_item());
        else send(random_read());
        sent++;
      end else if (pick < 90) begin
        send(header_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         3'($urandom_range(0, 7))));
        sent++;
      end else begin
        send(pixel_item(random_color()));
        sent++;
      end
    end
  endtask

  task automatic canvas_phase(input int unsigned w, input int unsigned h,
                              input logic [31:0] bg, input int unsigned n);
    settle();
    configure(w, h, bg);
    send(clear_item());
    random_traffic(n);
    send(random_read());
  endtask

  initial begin : result_sink
    int unsigned gap;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        gap = HoldCycles;
      end else begin
        if (sink_calm != 0) sink_calm--;
        else if ($urandom_range(0, 15) == 0) sink_calm = 20;
        gap = (sink_calm != 0) ? 0 : $urandom_range(0, 9);
      end
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_bus.valid && result_bus.ready));
    end
  end

  initial begin
    item_bus.valid <= 1'b0;
    item_bus.operation <= OpClear;
    item_bus.frame_left <= '0;
    item_bus.frame_top <= '0;
    item_bus.frame_width <= '0;
    item_bus.frame_height <= '0;
    item_bus.disposal <= '0;
    item_bus.pixel_color <= '0;
    item_bus.read_x <= '0;
    item_bus.read_y <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CfgCanvasWidth;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-size canvas: corners, alpha handling, clipping and the disposal cases.
    configure(MaxW, MaxH, 32'hFFFF_FFFF);
    send(clear_item());
    send(read_item(0, 0));
    send(read_item(255, 255));
    send(header_item(0, 0, 2, 2, DisposeRestoreBg));
    send(pixel_item(32'hFF12_3456));
    send(pixel_item(32'h00AB_CDEF));
    send(pixel_item(32'h0100_0000));
    send(pixel_item(32'h80FF_FFFF));
    send(pixel_item(32'hFFEE_DDCC));
    send(read_item(0, 0));
    send(read_item(1, 1));
    send(header_item(254, 255, 4, 1, DisposePrevious));
    send(pixel_item(32'hFF00_0001));
    send(pixel_item(32'hFF00_0002));
    send(pixel_item(32'hFF00_0003));
    send(read_item(255, 255));
    send(read_item(0, 0));
    send(header_item(65535, 65535, 65535, 65535, DisposeReservedTop));
    send(pixel_item(32'hFFFF_FFFE));
    // A zero-width frame advances one row per pixel.
    send(header_item(3, 3, 0, 3, DisposeRestoreBg));
    repeat (4) send(pixel_item(random_color() | 32'h0100_0000));
    send(header_item(0, 0, 5, 0, DisposeNone));
    send(pixel_item(32'hFFAA_5500));
    send(read_item(3, 5));
    send(read_item(0, 0));

    // Hold the result side off while reads keep coming, so the block backs up.
    hold_results = 1'b1;
    rush_items = 1'b1;
    repeat (40) send(random_read());
    rush_items = 1'b0;
    random_traffic(100);
    send(random_read());

    canvas_phase(1, 1, 32'h0000_0000, 90);
    canvas_phase(0, 7, $urandom, 60);
    canvas_phase(511, 3, $urandom, 110);
    canvas_phase(5, 400, $urandom, 110);
    repeat (4) canvas_phase($urandom_range(1, 48), $urandom_range(1, 48), $urandom, 130);

    settle();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
